[rtl/sacbp_pkg.sv]
// ============================================================================
// sacbp_pkg
// Shared types and constants of the set-associative cache tag engine with
// per-way recently-used bits.
// ============================================================================
package sacbp_pkg;

    // Cache geometry
    localparam int WAYS     = 8;
    localparam int SETS     = 1024;
    localparam int TAG_BITS = 20;

    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;

    // Fixed field widths of the transaction payloads
    localparam int IN_SET_BITS  = 10;
    localparam int IN_TAG_BITS  = 20;
    localparam int OUT_WAY_BITS = 3;
    localparam int CNT_BITS     = 32;

    typedef struct packed {
        logic                   kind;
        logic [IN_SET_BITS-1:0] set_index;
        logic [IN_TAG_BITS-1:0] tag_value;
    } sacbp_in_t;

    typedef struct packed {
        logic                    hit;
        logic [OUT_WAY_BITS-1:0] way_used;
        logic                    evicted;
        logic                    writeback;
        logic [CNT_BITS-1:0]     read_total;
        logic [CNT_BITS-1:0]     write_total;
        logic [CNT_BITS-1:0]     hit_total;
        logic [CNT_BITS-1:0]     miss_total;
        logic [CNT_BITS-1:0]     evict_total;
        logic [CNT_BITS-1:0]     writeback_total;
    } sacbp_out_t;

    // Access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Per-set policy bits
    typedef struct packed {
        logic [WAYS-1:0] used;
        logic [WAYS-1:0] dirty;
        logic [WAYS-1:0] valid;
    } meta_row_t;

    typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;

    // Controller <-> datapath
    typedef struct packed {
        logic accept;   // latch transaction, issue set read
        logic clear;    // write zero policy bits at sweep address
        logic update;   // write back set, bump counters, load result
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last; // sweep address is the last set
        logic out_free;   // result register can take a new result
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

[rtl/set_assoc_cache_bit_plru.sv]
// ============================================================================
// set_assoc_cache_bit_plru
// Tag and replacement engine of a set-associative cache with one
// recently-used bit per way.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_payload carry one access transaction: kind (read or
//   write), set index and tag. m_valid/m_ready/m_payload return exactly one
//   result per access: hit, way hit or filled, eviction and writeback flags,
//   and the six saturating counters after this access.
//   An accepted transaction's set is read into the read registers; the
//   lookup then loads its result into the result register and raises
//   m_valid once that register is free. An access is accepted only after
//   the last lookup has ended, set by the set read / set write-back loop
//   through the single port of the policy memory (read in the accept
//   cycle, write in the lookup cycle, so the next access always sees the
//   updated set). Reset: the counters and handshake state clear at once;
//   then a sweep zeroes the valid, dirty and used bits of all SETS (1024)
//   sets, one set per cycle. s_ready stays low for the sweep.
//   Stall: a waiting result sits in the output register while the next
//   transaction is accepted and its set is read; that lookup holds until
//   the receiver takes the earlier result.
// ============================================================================
module set_assoc_cache_bit_plru (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sacbp_pkg::sacbp_in_t  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sacbp_pkg::sacbp_out_t m_payload
);

    sacbp_pkg::ctrl_cmd_t  cmd;
    sacbp_pkg::dp_status_t status;

    // Sequencer: sweep, then accept and look up one access at a time
    sacbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Memories, lookup logic, counters and result register
    sacbp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Only one access in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("access accepted while another is in lookup");

    // A lookup always lands in the result register
    a_update_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid)
        else $error("lookup finished without a result");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_payload.hit && m_payload.evicted))
        else $error("hit reported together with eviction");

    // Writeback only on eviction
    a_wb_needs_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.evicted || !m_payload.writeback))
        else $error("writeback without eviction");

endmodule

[rtl/sacbp_ctrl.sv]
// ============================================================================
// sacbp_ctrl
// Sequencer: clearing sweep after reset, then accept / lookup per access.
// ============================================================================
module sacbp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sacbp_pkg::dp_status_t status,
    output sacbp_pkg::ctrl_cmd_t  cmd
);

    sacbp_pkg::state_t state_reg;
    sacbp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sacbp_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sacbp_pkg::ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = sacbp_pkg::ST_IDLE;
                end
            end
            sacbp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sacbp_pkg::ST_LOOKUP;
                end
            end
            sacbp_pkg::ST_LOOKUP: begin
                if (status.out_free) begin
                    state_next = sacbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sacbp_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            sacbp_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            sacbp_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            sacbp_pkg::ST_LOOKUP: begin
                cmd.update = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/sacbp_dp.sv]
// ============================================================================
// sacbp_dp
// Datapath: tag and policy memories, hit / victim selection, counters and
// the result register.
// ============================================================================
module sacbp_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sacbp_pkg::sacbp_in_t  s_payload,
    input  sacbp_pkg::ctrl_cmd_t  cmd,
    output sacbp_pkg::dp_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sacbp_pkg::sacbp_out_t m_payload
);

    localparam int SB = sacbp_pkg::SET_BITS;
    localparam int WB = sacbp_pkg::WAY_BITS;
    localparam int CB = sacbp_pkg::CNT_BITS;

    // Memories
    sacbp_pkg::meta_row_t meta_mem [sacbp_pkg::SETS];
    sacbp_pkg::tag_row_t  tag_mem  [sacbp_pkg::SETS];

    sacbp_pkg::meta_row_t meta_rd_reg;
    sacbp_pkg::tag_row_t  tag_rd_reg;

    // Transaction fields held through the lookup
    logic                          kind_reg;
    logic [SB-1:0]                 set_reg;
    logic [sacbp_pkg::TAG_BITS-1:0] tag_reg;

    logic [SB-1:0] clr_addr_reg;
    logic [SB-1:0] rd_addr;

    // Counters
    logic [CB-1:0] read_cnt_reg,  write_cnt_reg, hit_cnt_reg;
    logic [CB-1:0] miss_cnt_reg,  evict_cnt_reg, wb_cnt_reg;
    logic [CB-1:0] read_cnt_next, write_cnt_next, hit_cnt_next;
    logic [CB-1:0] miss_cnt_next, evict_cnt_next, wb_cnt_next;

    logic                  m_valid_reg;
    sacbp_pkg::sacbp_out_t out_reg;

    // Lookup results
    logic [sacbp_pkg::WAYS-1:0] hit_vec;
    logic                       hit;
    logic [WB-1:0]              hit_way, inv_way, unused_way, way;
    logic                       full, all_used, evicted, wb;
    logic [sacbp_pkg::WAYS-1:0] way_onehot;
    sacbp_pkg::meta_row_t       meta_new;
    sacbp_pkg::tag_row_t        tag_new;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c, input logic en);
        logic [CB-1:0] r;
        r = c;
        if (en && (c != '1)) begin
            r = c + CB'(1);
        end
        return r;
    endfunction

    assign rd_addr = s_payload.set_index[SB-1:0];

    // Policy bit memory: sweep write, update write, registered read
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            meta_mem[clr_addr_reg] <= '0;
        end else if (cmd.update) begin
            meta_mem[set_reg] <= meta_new;
        end
        if (cmd.accept) begin
            meta_rd_reg <= meta_mem[rd_addr];
        end
    end

    // Tag memory: written on fills only
    always_ff @(posedge aclk) begin
        if (cmd.update && !hit) begin
            tag_mem[set_reg] <= tag_new;
        end
        if (cmd.accept) begin
            tag_rd_reg <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg <= s_payload.kind;
            set_reg  <= s_payload.set_index[SB-1:0];
            tag_reg  <= s_payload.tag_value[sacbp_pkg::TAG_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear) begin
            clr_addr_reg <= clr_addr_reg + SB'(1);
        end
    end

    // Hit and victim search
    always_comb begin
        hit_way    = '0;
        inv_way    = '0;
        unused_way = '0;
        for (int i = sacbp_pkg::WAYS - 1; i >= 0; i--) begin
            hit_vec[i] = meta_rd_reg.valid[i] && (tag_rd_reg[i] == tag_reg);
            if (hit_vec[i]) begin
                hit_way = WB'(i);
            end
            if (!meta_rd_reg.valid[i]) begin
                inv_way = WB'(i);
            end
            if (!meta_rd_reg.used[i]) begin
                unused_way = WB'(i);
            end
        end
    end

    assign hit      = |hit_vec;
    assign full     = &meta_rd_reg.valid;
    assign all_used = &meta_rd_reg.used;

    always_comb begin
        priority if (hit) begin
            way = hit_way;
        end else if (!full) begin
            way = inv_way;
        end else if (!all_used) begin
            way = unused_way;
        end else begin
            way = '0;
        end
    end

    assign evicted    = !hit && full;
    assign wb         = evicted && meta_rd_reg.dirty[way];
    assign way_onehot = sacbp_pkg::WAYS'(1) << way;

    always_comb begin
        meta_new = meta_rd_reg;
        tag_new  = tag_rd_reg;
        if (evicted && all_used) begin
            meta_new.used = '0;
        end
        meta_new.used  = meta_new.used | way_onehot;
        meta_new.valid = meta_rd_reg.valid | way_onehot;
        if (hit) begin
            if (kind_reg == sacbp_pkg::KIND_WRITE) begin
                meta_new.dirty[way] = 1'b1;
            end
        end else begin
            meta_new.dirty[way] = (kind_reg == sacbp_pkg::KIND_WRITE);
            tag_new[way]        = tag_reg;
        end
    end

    assign read_cnt_next  = sat_inc(read_cnt_reg,  kind_reg == sacbp_pkg::KIND_READ);
    assign write_cnt_next = sat_inc(write_cnt_reg, kind_reg == sacbp_pkg::KIND_WRITE);
    assign hit_cnt_next   = sat_inc(hit_cnt_reg,   hit);
    assign miss_cnt_next  = sat_inc(miss_cnt_reg,  !hit);
    assign evict_cnt_next = sat_inc(evict_cnt_reg, evicted);
    assign wb_cnt_next    = sat_inc(wb_cnt_reg,    wb);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_cnt_reg  <= '0;
            write_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            wb_cnt_reg    <= '0;
        end else if (cmd.update) begin
            read_cnt_reg  <= read_cnt_next;
            write_cnt_reg <= write_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
            wb_cnt_reg    <= wb_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            out_reg.hit             <= hit;
            out_reg.way_used        <= sacbp_pkg::OUT_WAY_BITS'(way);
            out_reg.evicted         <= evicted;
            out_reg.writeback       <= wb;
            out_reg.read_total      <= read_cnt_next;
            out_reg.write_total     <= write_cnt_next;
            out_reg.hit_total       <= hit_cnt_next;
            out_reg.miss_total      <= miss_cnt_next;
            out_reg.evict_total     <= evict_cnt_next;
            out_reg.writeback_total <= wb_cnt_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    assign status.clear_last = (clr_addr_reg == SB'(sacbp_pkg::SETS - 1));
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule
